// ===== rtl/core/bcg_pkg.sv =====
// Shared types and constants of the binomial coefficient unit.
// Used by bcg_ctrl, bcg_datapath and binomial_coefficient_gcd; no dependencies.
package bcg_pkg;

  // Field and word widths
  localparam int N_W      = 6;
  localparam int WORD_W   = 64;
  localparam int COEF_W   = 63;
  localparam int PROD_W   = WORD_W + N_W;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  // Largest set size accepted; larger inputs saturate to it
  localparam logic [N_W-1:0] MAX_N = 6'd63;

  // Divider iteration count and its counter width
  localparam int DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'(WORD_W);

  // Count of common factors of two stripped in the gcd loop
  localparam int K_W = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [N_W-1:0]    count_t;

  // Divider operand select
  localparam logic SEL_NUM = 1'b0;
  localparam logic SEL_DEN = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic div_store;
    logic div_sel;
    logic dec;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic r_zero;
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage

// ===== rtl/core/bcg_datapath.sv =====
// Datapath of the binomial coefficient unit: operand registers, round
// multiplier, binary gcd, restoring divider and output register. Uses bcg_pkg.
module bcg_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bcg_pkg::cmd_t                    cmd_i,
  output bcg_pkg::status_t                 status_o,
  input  logic [bcg_pkg::IN_TDATA_W-1:0]   in_data_i,
  output logic [bcg_pkg::OUT_TDATA_W-1:0]  out_data_o
);
  import bcg_pkg::*;

  count_t n_r, r_r;
  word_t  num_r, den_r;
  logic   ovf_r;

  word_t  gcd_a_r, gcd_b_r;
  logic [K_W-1:0] gcd_k_r;

  word_t  div_quot_r, div_rem_r, div_dvsr_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [COEF_W-1:0] coef_r;
  logic              out_ovf_r;

  count_t n_in, r_in, n_sat, r_sat, r_alt;
  logic [PROD_W-1:0] prod_num, prod_den;
  word_t  g_raw, g_shift, g_eff;
  logic   gcd_done;
  logic [WORD_W:0] div_trial;
  logic   div_fit;

  // Input unpacking, saturation and the symmetric choice count
  always_comb begin
    n_in  = in_data_i[N_W-1:0];
    r_in  = in_data_i[2*N_W-1:N_W];
    n_sat = (n_in > MAX_N) ? MAX_N : n_in;
    r_sat = (r_in > MAX_N) ? MAX_N : r_in;
    r_alt = n_sat - r_sat;
  end

  // Round products, 70 bits wide so the overflow is seen in the top bits
  always_comb begin
    prod_num = PROD_W'(num_r) * PROD_W'(n_r);
    prod_den = PROD_W'(den_r) * PROD_W'(r_r);
  end

  // The gcd is the surviving nonzero operand scaled by the stripped twos;
  // a zero gcd (both operands wrapped to zero) is taken as one.
  always_comb begin
    gcd_done = (gcd_a_r == '0) || (gcd_b_r == '0) || (gcd_a_r == gcd_b_r);
    g_raw    = (gcd_a_r == '0) ? gcd_b_r : gcd_a_r;
    g_shift  = g_raw << gcd_k_r;
    g_eff    = (g_shift == '0) ? WORD_W'(1) : g_shift;
  end

  // One restoring division step
  always_comb begin
    div_trial = {div_rem_r, div_quot_r[WORD_W-1]};
    div_fit   = (div_trial >= {1'b0, div_dvsr_r});
  end

  // Operand registers: load, multiply, store quotients, step down
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      n_r   <= n_sat;
      num_r <= (r_sat > n_sat) ? '0 : WORD_W'(1);
      den_r <= WORD_W'(1);
      ovf_r <= 1'b0;
      if (r_sat > n_sat) begin
        r_r <= '0;
      end else if (r_alt < r_sat) begin
        r_r <= r_alt;
      end else begin
        r_r <= r_sat;
      end
    end
    if (cmd_i.mul) begin
      num_r <= prod_num[WORD_W-1:0];
      den_r <= prod_den[WORD_W-1:0];
      ovf_r <= ovf_r | (|prod_num[PROD_W-1:WORD_W]) | (|prod_den[PROD_W-1:WORD_W]);
    end
    if (cmd_i.div_store) begin
      if (cmd_i.div_sel == SEL_DEN) begin
        den_r <= div_quot_r;
      end else begin
        num_r <= div_quot_r;
      end
    end
    if (cmd_i.dec) begin
      n_r <= n_r - count_t'(1);
      r_r <= r_r - count_t'(1);
    end
  end

  // Binary gcd: strip common twos, halve even operands, subtract odd ones
  always_ff @(posedge clk) begin
    if (cmd_i.gcd_init) begin
      gcd_a_r <= num_r;
      gcd_b_r <= den_r;
      gcd_k_r <= '0;
    end else if (cmd_i.gcd_step && !gcd_done) begin
      if (!gcd_a_r[0] && !gcd_b_r[0]) begin
        gcd_a_r <= gcd_a_r >> 1;
        gcd_b_r <= gcd_b_r >> 1;
        gcd_k_r <= gcd_k_r + K_W'(1);
      end else if (!gcd_a_r[0]) begin
        gcd_a_r <= gcd_a_r >> 1;
      end else if (!gcd_b_r[0]) begin
        gcd_b_r <= gcd_b_r >> 1;
      end else if (gcd_a_r > gcd_b_r) begin
        gcd_a_r <= gcd_a_r - gcd_b_r;
      end else begin
        gcd_b_r <= gcd_b_r - gcd_a_r;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd_i.div_init) begin
      div_cnt_r <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.div_init) begin
      div_quot_r <= (cmd_i.div_sel == SEL_DEN) ? den_r : num_r;
      div_rem_r  <= '0;
      div_dvsr_r <= g_eff;
    end else if (cmd_i.div_step) begin
      if (div_fit) begin
        div_rem_r  <= div_trial[WORD_W-1:0] - div_dvsr_r;
        div_quot_r <= {div_quot_r[WORD_W-2:0], 1'b1};
      end else begin
        div_rem_r  <= div_trial[WORD_W-1:0];
        div_quot_r <= {div_quot_r[WORD_W-2:0], 1'b0};
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      coef_r    <= num_r[COEF_W-1:0];
      out_ovf_r <= ovf_r;
    end
  end

  assign out_data_o = {out_ovf_r, coef_r};

  assign status_o.r_zero   = (r_r == '0);
  assign status_o.gcd_done = gcd_done;
  assign status_o.div_done = (div_cnt_r == DIV_STEPS);

  // The divider is never stepped past its last quotient bit
  a_div_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.div_step |-> (div_cnt_r < DIV_STEPS))
    else $error("divider stepped past its last quotient bit");

endmodule

// ===== rtl/core/bcg_ctrl.sv =====
// Controller of the binomial coefficient unit: sequences load, rounds of
// multiply, gcd and two divides, and the output handshake. Uses bcg_pkg.
module bcg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  bcg_pkg::status_t status_i,
  output bcg_pkg::cmd_t    cmd_o
);
  import bcg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_GINIT  = 4'd3;
  localparam logic [3:0] S_GSTEP  = 4'd4;
  localparam logic [3:0] S_DNINIT = 4'd5;
  localparam logic [3:0] S_DNUM   = 4'd6;
  localparam logic [3:0] S_DDINIT = 4'd7;
  localparam logic [3:0] S_DDEN   = 4'd8;
  localparam logic [3:0] S_DEC    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = status_i.r_zero ? S_DONE : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = S_GINIT;
      end
      S_GINIT: begin
        cmd_o.gcd_init = 1'b1;
        state_nxt      = S_GSTEP;
      end
      S_GSTEP: begin
        if (status_i.gcd_done) begin
          state_nxt = S_DNINIT;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DNINIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.div_sel  = SEL_NUM;
        state_nxt      = S_DNUM;
      end
      S_DNUM: begin
        cmd_o.div_sel = SEL_NUM;
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_nxt       = S_DDINIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DDINIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.div_sel  = SEL_DEN;
        state_nxt      = S_DDEN;
      end
      S_DDEN: begin
        cmd_o.div_sel = SEL_DEN;
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_nxt       = S_DEC;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        state_nxt = S_CHECK;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output word stays valid until it is taken
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted word always starts a round check
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted word did not start the round sequence");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |-> (!out_valid_r || out_tready))
    else $error("output word overwritten before it was taken");

  // The numerator division keeps running until its count completes
  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DNUM && !status_i.div_done) |=> (state_r == S_DNUM))
    else $error("numerator division left early");

  // Each round ends with a step down of both counts and a new check
  a_dec_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.dec |=> (state_r == S_CHECK))
    else $error("round did not return to the check state");

endmodule

// ===== rtl/core/binomial_coefficient_gcd.sv =====
// Binomial coefficient unit: top level joining bcg_ctrl and bcg_datapath.
// Uses bcg_pkg.
//
// Takes a set size n and a choice count r (both saturated to 63) and returns
// C(n, r) in 63 bits with an overflow flag; r > n gives 0 and r = 0 gives 1.
// One word is worked on at a time. After acceptance r is reduced to
// min(r, n - r), then each of the r rounds runs the control states, a
// multiply, a binary gcd and two divides in the single shared restoring
// divider. The finished word sits in an output register, so the next input
// is accepted while it waits.
module binomial_coefficient_gcd (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata: [5:0] n_total, [11:6] choose_count, [15:12] zero
  input  logic [bcg_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: [62:0] coefficient, [63] overflow
  output logic [bcg_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import bcg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  bcg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and result register
  bcg_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_tdata),
    .out_data_o (out_tdata)
  );

endmodule
